>>> sv/tipd_pkg.sv
// Shared types, constants and the signature table of the tape image pulse decoder.
`timescale 1ns / 1ps

package tipd_pkg;

    localparam int HDR_LEN     = 20;
    localparam int SIG_LEN     = 12;
    localparam int VERSION_POS = 12;
    localparam int LENGTH_POS  = 16;
    localparam int MAX_VERSION = 2;

    localparam logic [23:0] V0_ZERO_CYCLES = 24'd2048;

    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    localparam logic KIND_PULSE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        ERR_OK          = 3'd0,
        ERR_TOO_SMALL   = 3'd1,
        ERR_BAD_SIG     = 3'd2,
        ERR_BAD_VERSION = 3'd3,
        ERR_NO_PULSES   = 3'd4
    } err_code_t;

    typedef struct packed {
        logic        item_kind;
        logic [23:0] pulse_cycles;
        err_code_t   error_code;
        logic        half_wave;
        logic        final_item;
    } result_t;

    // Expected header signature, one character per header position.
    function automatic logic [7:0] sig_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h43;
            4'd1:    c = 8'h36;
            4'd2:    c = 8'h34;
            4'd3:    c = 8'h2D;
            4'd4:    c = 8'h54;
            4'd5:    c = 8'h41;
            4'd6:    c = 8'h50;
            4'd7:    c = 8'h45;
            4'd8:    c = 8'h2D;
            4'd9:    c = 8'h52;
            4'd10:   c = 8'h41;
            4'd11:   c = 8'h57;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> sv/tipd_res_fifo.sv
// Result queue that takes up to two items per cycle and gives one per cycle.
`timescale 1ns / 1ps

module tipd_res_fifo (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push0,
    input  logic                      push1,
    input  tipd_pkg::result_t         din0,
    input  tipd_pkg::result_t         din1,
    input  logic                      pop,
    output tipd_pkg::result_t         dout,
    output logic                      not_empty,
    output logic [tipd_pkg::FIFO_AW:0] level
);
    import tipd_pkg::*;

    result_t             mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg;
    logic [FIFO_AW-1:0]  rd_ptr_reg;
    logic [FIFO_AW:0]    level_reg;
    logic [FIFO_AW:0]    push_cnt;
    logic [FIFO_AW:0]    pop_cnt;

    // The second push port is only used together with the first one.
    assign push_cnt = {{FIFO_AW{1'b0}}, push0} + {{FIFO_AW{1'b0}}, push0 & push1};
    assign pop_cnt  = {{FIFO_AW{1'b0}}, pop};

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            mem[wr_ptr_reg] <= din0;
        end
        if (push0 && push1)
        begin
            mem[wr_ptr_reg + FIFO_AW'(1)] <= din1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push_cnt[FIFO_AW-1:0];
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            level_reg <= level_reg + push_cnt - pop_cnt;
        end
    end

    assign dout      = mem[rd_ptr_reg];
    assign not_empty = (level_reg != '0);
    assign level     = level_reg;

endmodule

>>> sv/tape_image_pulse_decoder.sv
// Top level of the tape image pulse decoder: header check, pulse decoding and result queue.
`timescale 1ns / 1ps

// Usage:
// The slave stream carries the raw tape image, one byte per item, with tlast on the
// final byte. The first 20 bytes are the header (signature, version, data length);
// later bytes are decoded into pulse length items on the master stream.
// On the final byte a status item follows, with tlast high, and the decoder returns
// to its reset state so that the next image may start on the next item.
// A result item is written into the result queue when the byte that causes it is
// accepted. Throughput: one byte per cycle while the queue has room; a final byte that also
// completes a pulse queues two items, which the master side drains one per cycle.
// Input acceptance depends only on the fill level of the four-entry result queue, so
// there is no combinational path from m_axis_tready to s_axis_tready. When the
// receiver stalls, the queue fills and s_axis_tready drops once fewer than two entries
// are free; nothing is lost. Reset clears the header and data state and empties the
// queue.

module tape_image_pulse_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] tape_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [23:0] pulse_cycles, [26:24] error_code,
                                        // [27] half_wave, [31:28] zero
    output logic [0:0]  m_axis_tuser,   // [0] item_kind
    output logic        m_axis_tlast
);
    import tipd_pkg::*;

    logic [4:0]  hdr_pos_reg,  hdr_pos_next;
    logic        sig_ok_reg,   sig_ok_next;
    logic [7:0]  version_reg,  version_next;
    logic [31:0] decl_len_reg, decl_len_next;
    logic [31:0] data_cnt_reg, data_cnt_next;
    logic [1:0]  esc_phase_reg, esc_phase_next;
    logic [15:0] esc_val_reg,  esc_val_next;
    logic        any_pulse_reg, any_pulse_next;
    logic        stopped_reg,  stopped_next;

    logic        accept;
    logic [7:0]  b;
    logic        in_header;
    logic        hdr_valid;
    logic        emit;
    logic [23:0] cycles;
    logic [23:0] esc_full;
    result_t     pulse_item;
    result_t     status_item;
    result_t     push_a;
    logic        push0;
    logic        push1;
    result_t     q_out;
    logic        q_not_empty;
    logic [FIFO_AW:0] q_level;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (q_level <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
    assign b             = s_axis_tdata;
    assign in_header     = (hdr_pos_reg < 5'(HDR_LEN));
    assign hdr_valid     = !in_header && sig_ok_reg && (version_reg <= 8'(MAX_VERSION));
    assign esc_full      = {b, esc_val_reg};

    always_comb
    begin
        hdr_pos_next   = hdr_pos_reg;
        sig_ok_next    = sig_ok_reg;
        version_next   = version_reg;
        decl_len_next  = decl_len_reg;
        data_cnt_next  = data_cnt_reg;
        esc_phase_next = esc_phase_reg;
        esc_val_next   = esc_val_reg;
        any_pulse_next = any_pulse_reg;
        stopped_next   = stopped_reg;
        emit           = 1'b0;
        cycles         = '0;

        if (in_header)
        begin
            if (hdr_pos_reg < 5'(SIG_LEN))
            begin
                if (b != sig_char(hdr_pos_reg[3:0]))
                begin
                    sig_ok_next = 1'b0;
                end
            end
            else if (hdr_pos_reg == 5'(VERSION_POS))
            begin
                version_next = b;
            end
            else if (hdr_pos_reg >= 5'(LENGTH_POS))
            begin
                // Positions 16 to 19 hold the length, lowest byte first.
                decl_len_next[hdr_pos_reg[1:0]*8 +: 8] = b;
            end
            hdr_pos_next = hdr_pos_reg + 5'd1;
        end
        else if (hdr_valid && !stopped_reg)
        begin
            if (esc_phase_reg == 2'd0)
            begin
                if (b != 8'd0)
                begin
                    cycles = {13'd0, b, 3'd0};
                    emit   = 1'b1;
                end
                else if (version_reg == 8'd0)
                begin
                    cycles = V0_ZERO_CYCLES;
                    emit   = 1'b1;
                end
                else
                begin
                    esc_phase_next = 2'd1;
                    esc_val_next   = '0;
                end
            end
            else if (esc_phase_reg == 2'd1)
            begin
                esc_val_next[7:0] = b;
                esc_phase_next    = 2'd2;
            end
            else if (esc_phase_reg == 2'd2)
            begin
                esc_val_next[15:8] = b;
                esc_phase_next     = 2'd3;
            end
            else
            begin
                // A count of zero still gives the shortest possible pulse.
                cycles         = (esc_full == 24'd0) ? 24'd1 : esc_full;
                emit           = 1'b1;
                esc_phase_next = 2'd0;
            end

            if (decl_len_reg != 32'd0)
            begin
                data_cnt_next = data_cnt_reg + 32'd1;
                if (data_cnt_next == decl_len_reg)
                begin
                    stopped_next = 1'b1;
                end
            end
            if (emit)
            begin
                any_pulse_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        pulse_item.item_kind    = KIND_PULSE;
        pulse_item.pulse_cycles = cycles;
        pulse_item.error_code   = ERR_OK;
        pulse_item.half_wave    = (version_reg == 8'd2);
        pulse_item.final_item   = 1'b0;

        status_item.item_kind    = KIND_STATUS;
        status_item.pulse_cycles = '0;
        status_item.half_wave    = 1'b0;
        status_item.final_item   = 1'b1;
        if (hdr_pos_next < 5'(HDR_LEN))
        begin
            status_item.error_code = ERR_TOO_SMALL;
        end
        else if (!sig_ok_next)
        begin
            status_item.error_code = ERR_BAD_SIG;
        end
        else if (version_next > 8'(MAX_VERSION))
        begin
            status_item.error_code = ERR_BAD_VERSION;
        end
        else
        begin
            status_item.half_wave  = (version_next == 8'd2);
            status_item.error_code = any_pulse_next ? ERR_OK : ERR_NO_PULSES;
        end
    end

    assign push0  = accept && (emit || s_axis_tlast);
    assign push1  = accept && emit && s_axis_tlast;
    assign push_a = emit ? pulse_item : status_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_pos_reg   <= '0;
            sig_ok_reg    <= 1'b1;
            version_reg   <= '0;
            decl_len_reg  <= '0;
            data_cnt_reg  <= '0;
            esc_phase_reg <= '0;
            esc_val_reg   <= '0;
            any_pulse_reg <= 1'b0;
            stopped_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (s_axis_tlast)
            begin
                hdr_pos_reg   <= '0;
                sig_ok_reg    <= 1'b1;
                version_reg   <= '0;
                decl_len_reg  <= '0;
                data_cnt_reg  <= '0;
                esc_phase_reg <= '0;
                esc_val_reg   <= '0;
                any_pulse_reg <= 1'b0;
                stopped_reg   <= 1'b0;
            end
            else
            begin
                hdr_pos_reg   <= hdr_pos_next;
                sig_ok_reg    <= sig_ok_next;
                version_reg   <= version_next;
                decl_len_reg  <= decl_len_next;
                data_cnt_reg  <= data_cnt_next;
                esc_phase_reg <= esc_phase_next;
                esc_val_reg   <= esc_val_next;
                any_pulse_reg <= any_pulse_next;
                stopped_reg   <= stopped_next;
            end
        end
    end

    tipd_res_fifo u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push0     (push0),
        .push1     (push1),
        .din0      (push_a),
        .din1      (status_item),
        .pop       (m_axis_tvalid && m_axis_tready),
        .dout      (q_out),
        .not_empty (q_not_empty),
        .level     (q_level)
    );

    assign m_axis_tvalid = q_not_empty;
    assign m_axis_tdata  = {4'd0, q_out.half_wave, q_out.error_code, q_out.pulse_cycles};
    assign m_axis_tuser  = q_out.item_kind;
    assign m_axis_tlast  = q_out.final_item;

    // A byte is only taken while the queue has room for both of its results.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (q_level <= (FIFO_AW + 1)'(FIFO_DEPTH - 2)))
        else $error("result queue accepted a byte without room for two items");

    // The final byte always brings the decoder back to the start of a header.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tlast) |=> (hdr_pos_reg == 5'd0 && sig_ok_reg && !stopped_reg))
        else $error("decoder state not cleared after the final byte");

    // Status items carry no pulse length and always close the image.
    a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0] == KIND_STATUS) |->
        (m_axis_tdata[23:0] == 24'd0 && m_axis_tlast))
        else $error("malformed status item");

    // Pulse items are never zero length and never carry an error.
    a_pulse_form: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0] == KIND_PULSE) |->
        (m_axis_tdata[23:0] != 24'd0 && m_axis_tdata[26:24] == 3'd0 && !m_axis_tlast))
        else $error("malformed pulse item");

endmodule
